// ===== rtl/psgc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psgc_pkg
// shared types, constants and register map of the sepia / gray converter
// ----------------------------------------------------------------------------
package psgc_pkg;

   localparam int CHANNEL_BITS = 16;
   localparam logic [15:0] CHAN_MASK = 16'((32'd1 << CHANNEL_BITS) - 32'd1);

   localparam int DIV_STEPS = 16;
   localparam logic [15:0] GRAY_SAT = 16'hFFFF;

   // sepia matrix, unsigned q0.16, rows red / green / blue
   localparam logic [15:0] SEPIA_COEF [3][3] = '{
      '{16'd25756, 16'd50397, 16'd12386},
      '{16'd22872, 16'd44958, 16'd11010},
      '{16'd17826, 16'd34996, 16'd8585}
   };

   typedef enum logic [1:0] {
      REG_SEPIA_ENABLE = 2'd0,
      REG_IMAGE_MAX    = 2'd1,
      REG_GRAY_MAX     = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
      logic [15:0] gray_level;
      logic        dark_bit;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/pixel_sepia_gray_convert_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_sepia_gray_convert_top
// sepia tone, grayscale level and bilevel bit, while rsp does not stall, of one rgb pixel per clock
// ----------------------------------------------------------------------------
// usage:
//  - req channel takes one pixel per request (valid / ready), rsp channel
//    returns the converted channels, gray level and dark bit (valid / ready)
//  - csr apb port: sepia_enable at 0x0, image_max at 0x4, gray_max at 0x8;
//    write only while no request is in flight
//  - one request per cycle sustained while rsp does not stall; a request
//    passes the 21 stage pipeline (four arithmetic stages, a 17 stage
//    bit-per-stage divider) followed by the output register
//  - reset empties the pipeline and sets sepia off, both maxima to 255
//  - when rsp stalls, a skid register catches the result in flight and
//    req_ready drops until the skid register drains; nothing is lost
// ----------------------------------------------------------------------------
module pixel_sepia_gray_convert_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire psgc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output psgc_pkg::rsp_type      rsp_data,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [3:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import psgc_pkg::*;

   logic        sepia_enable_ff;
   logic [15:0] image_max_ff;
   logic [15:0] gray_max_ff;
   logic [17:0] den;
   logic        en;
   logic        csr_wr;

   logic        s1_valid_ff;
   logic [31:0] s1_prod_ff [3][3];
   logic [15:0] s1_chan_ff [3];
   logic [15:0] chan_in [3];

   logic        s2_valid_ff;
   logic [15:0] s2_res_ff [3];
   logic [15:0] res_in [3];

   logic        s3_valid_ff;
   logic [15:0] s3_res_ff [3];
   logic [17:0] s3_sum_ff;
   logic        s3_dark_ff;
   logic [17:0] sum_in;

   logic        s4_valid_ff;
   logic [33:0] s4_num_ff;
   rsp_type     s4_side_ff;
   rsp_type     side_in;

   logic        div_valid;
   rsp_type     div_data;
   logic        consume;
   logic        take;

   logic        out_valid_ff;
   rsp_type     out_ff;
   logic        skid_valid_ff;
   rsp_type     skid_ff;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         sepia_enable_ff <= 1'b0;
         image_max_ff    <= 16'd255;
         gray_max_ff     <= 16'd255;
      end else if (csr_wr) begin
         case (reg_index_type'(csr_paddr[3:2]))
            REG_SEPIA_ENABLE: sepia_enable_ff <= csr_pwdata[0];
            REG_IMAGE_MAX:    image_max_ff    <= csr_pwdata[15:0];
            REG_GRAY_MAX:     gray_max_ff     <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_paddr[3:2]))
         REG_SEPIA_ENABLE: csr_prdata = {31'd0, sepia_enable_ff};
         REG_IMAGE_MAX:    csr_prdata = {16'd0, image_max_ff};
         REG_GRAY_MAX:     csr_prdata = {16'd0, gray_max_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign den = 18'({image_max_ff, 1'b0}) + 18'(image_max_ff);

   // pipeline advances while the skid register is empty
   assign en        = ~skid_valid_ff;
   assign req_ready = en;

   // stage 1: sepia products
   assign chan_in[0] = req_data.red_in   & CHAN_MASK;
   assign chan_in[1] = req_data.green_in & CHAN_MASK;
   assign chan_in[2] = req_data.blue_in  & CHAN_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            s1_chan_ff[r] <= chan_in[r];
            for (int c = 0; c < 3; c++) begin
               s1_prod_ff[r][c] <= SEPIA_COEF[r][c] * chan_in[c];
            end
         end
      end
   end

   // stage 2: sum, truncate, clamp, select
   always_comb begin
      logic [33:0] acc;
      logic [17:0] trunc;
      for (int r = 0; r < 3; r++) begin
         acc   = 34'(s1_prod_ff[r][0]) + 34'(s1_prod_ff[r][1]) + 34'(s1_prod_ff[r][2]);
         trunc = acc[33:16];
         if (trunc > 18'(image_max_ff)) begin
            trunc = 18'(image_max_ff);
         end
         res_in[r] = sepia_enable_ff ? trunc[15:0] : s1_chan_ff[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_res_ff <= res_in;
      end
   end

   // stage 3: channel sum and dark bit
   assign sum_in = 18'(s2_res_ff[0]) + 18'(s2_res_ff[1]) + 18'(s2_res_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_res_ff  <= s2_res_ff;
         s3_sum_ff  <= sum_in;
         s3_dark_ff <= ({sum_in, 1'b0} < {1'b0, den});
      end
   end

   // stage 4: scale by gray maximum
   always_comb begin
      side_in            = '0;
      side_in.red_out    = s3_res_ff[0];
      side_in.green_out  = s3_res_ff[1];
      side_in.blue_out   = s3_res_ff[2];
      side_in.dark_bit   = s3_dark_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_num_ff  <= s3_sum_ff * gray_max_ff;
         s4_side_ff <= side_in;
      end
   end

   psgc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s4_valid_ff),
      .num       (s4_num_ff),
      .den       (den),
      .in_side   (s4_side_ff),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // output register with skid
   assign consume = en & div_valid;
   assign take    = out_valid_ff & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (~out_valid_ff | take) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= consume;
               out_ff       <= div_data;
            end
         end else if (consume) begin
            skid_ff       <= div_data;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("skid register drained without a taken result");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_ready))
      else $error("skid register filled while output was free");

endmodule
`default_nettype wire

// ===== rtl/psgc_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psgc_divider
// pipelined restoring divider, one quotient bit per stage, saturating at 16 bits
// ----------------------------------------------------------------------------
module psgc_divider (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [33:0]      num,
   input  wire logic [17:0]      den,
   input  wire psgc_pkg::rsp_type in_side,
   output logic                  out_valid,
   output psgc_pkg::rsp_type     out_data
);
   import psgc_pkg::*;

   typedef struct packed {
      logic        valid;
      logic [17:0] rem;
      logic [15:0] low;
      logic [15:0] quo;
      logic        zero;
      logic        sat;
      rsp_type     side;
   } div_stage_type;

   div_stage_type stage_ff [DIV_STEPS+1];
   div_stage_type stage_in [DIV_STEPS+1];

   always_comb begin
      stage_in[0].valid = in_valid;
      stage_in[0].rem   = num[33:16];
      stage_in[0].low   = num[15:0];
      stage_in[0].quo   = '0;
      stage_in[0].zero  = (num == 34'd0);
      stage_in[0].sat   = (num >= {den, 16'd0});
      stage_in[0].side  = in_side;
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [18:0] trial;
      logic [18:0] diff;
      logic        ge;
      always_comb begin
         trial = {stage_ff[k-1].rem, stage_ff[k-1].low[15]};
         diff  = trial - {1'b0, den};
         ge    = (trial >= {1'b0, den});
         stage_in[k]       = stage_ff[k-1];
         stage_in[k].rem   = ge ? diff[17:0] : trial[17:0];
         stage_in[k].low   = {stage_ff[k-1].low[14:0], 1'b0};
         stage_in[k].quo   = {stage_ff[k-1].quo[14:0], ge};
      end
   end

   for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else if (en) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   always_comb begin
      out_valid = stage_ff[DIV_STEPS].valid;
      out_data  = stage_ff[DIV_STEPS].side;
      if (stage_ff[DIV_STEPS].zero) begin
         out_data.gray_level = '0;
      end else if (stage_ff[DIV_STEPS].sat) begin
         out_data.gray_level = GRAY_SAT;
      end else begin
         out_data.gray_level = stage_ff[DIV_STEPS].quo;
      end
   end

endmodule
`default_nettype wire

// ===== tb/pixel_sepia_gray_convert_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_sepia_gray_convert_top_test
// drives pixels through the sepia / gray converter under several register
// settings with random gaps on both sides, predicts every result in the
// testbench and compares each returned result with the oldest prediction
// ----------------------------------------------------------------------------
module pixel_sepia_gray_convert_top_test;
   import psgc_pkg::*;

   localparam logic [3:0] ADDR_SEPIA = 4'(4 * REG_SEPIA_ENABLE);
   localparam logic [3:0] ADDR_IMAGE = 4'(4 * REG_IMAGE_MAX);
   localparam logic [3:0] ADDR_GRAY  = 4'(4 * REG_GRAY_MAX);
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LATENCY = 22;

   class pixel_scoreboard;
      rsp_type pending_pixels[$];
      bit      sepia_on;
      int unsigned img_max;
      int unsigned gry_max;
      int      error_count;

      function new();
         sepia_on = 0;
         img_max = 255;
         gry_max = 255;
         error_count = 0;
      endfunction

      function void note_request(req_type req);
         longint unsigned ch[3];
         longint unsigned res[3];
         longint unsigned acc, total, den, gray;
         rsp_type exp_rsp;
         ch[0] = 64'(req.red_in & CHAN_MASK);
         ch[1] = 64'(req.green_in & CHAN_MASK);
         ch[2] = 64'(req.blue_in & CHAN_MASK);
         for (int k = 0; k < 3; k++) begin
            if (sepia_on) begin
               acc = 0;
               for (int j = 0; j < 3; j++) acc += 64'(SEPIA_COEF[k][j]) * ch[j];
               acc = acc >> 16;
               res[k] = (acc > 64'(img_max)) ? 64'(img_max) : acc;
            end else begin
               res[k] = ch[k];
            end
         end
         total = res[0] + res[1] + res[2];
         den = 64'(img_max) * 64'd3;
         if (den == 0) gray = (total == 0 || gry_max == 0) ? 64'd0 : 64'd65535;
         else gray = (total * 64'(gry_max)) / den;
         if (gray > 64'd65535) gray = 64'd65535;
         exp_rsp.red_out = res[0][15:0];
         exp_rsp.green_out = res[1][15:0];
         exp_rsp.blue_out = res[2][15:0];
         exp_rsp.gray_level = gray[15:0];
         exp_rsp.dark_bit = (64'd2 * total < den);
         pending_pixels.push_back(exp_rsp);
      endfunction

      task check_result(rsp_type got);
         rsp_type exp_rsp;
         if (pending_pixels.size() == 0) begin
            report_mismatch("result with no request pending", 64'd0, 64'(got));
            return;
         end
         exp_rsp = pending_pixels.pop_front();
         if (got.red_out !== exp_rsp.red_out)
            report_mismatch("red_out", 64'(exp_rsp.red_out), 64'(got.red_out));
         if (got.green_out !== exp_rsp.green_out)
            report_mismatch("green_out", 64'(exp_rsp.green_out), 64'(got.green_out));
         if (got.blue_out !== exp_rsp.blue_out)
            report_mismatch("blue_out", 64'(exp_rsp.blue_out), 64'(got.blue_out));
         if (got.gray_level !== exp_rsp.gray_level)
            report_mismatch("gray_level", 64'(exp_rsp.gray_level), 64'(got.gray_level));
         if (got.dark_bit !== exp_rsp.dark_bit)
            report_mismatch("dark_bit", 64'(exp_rsp.dark_bit), 64'(got.dark_bit));
      endtask

      task report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
         $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
         error_count++;
      endtask
   endclass

   logic clock, reset;
   logic req_valid, req_ready;
   req_type req_data;
   logic rsp_valid, rsp_ready;
   rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [3:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   pixel_scoreboard pixel_board;
   bit stimulus_done;
   bit hold_off;
   int idle_cycles;
   int rsp_gap;

   pixel_sepia_gray_convert_top DUT (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      stimulus_done = 0;
      hold_off = 0;
      pixel_board = new();
   end

   task automatic write_reg(logic [3:0] addr, logic [31:0] value);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_SEPIA) pixel_board.sepia_on = value[0];
      else if (addr == ADDR_IMAGE) pixel_board.img_max = 32'(value[15:0]);
      else if (addr == ADDR_GRAY) pixel_board.gry_max = 32'(value[15:0]);
   endtask

   task automatic configure(bit sep, logic [31:0] imax, logic [31:0] gmax);
      req_valid <= 0;
      while (pixel_board.pending_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      write_reg(ADDR_SEPIA, {$urandom} & 32'hFFFF_FFFE | 32'(sep));
      write_reg(ADDR_IMAGE, {16'($urandom_range(0, 65535)), imax[15:0]});
      write_reg(ADDR_GRAY, {16'($urandom_range(0, 65535)), gmax[15:0]});
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{red_in: r, green_in: g, blue_in: b};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixel_board.note_request(req_data);
   endtask

   task automatic random_pixel(int unsigned imax, bit gaps);
      int unsigned top;
      top = (imax == 0) ? 3 : imax;
      case ($urandom_range(0, 3))
         0: send_pixel(16'($urandom), 16'($urandom), 16'($urandom), gaps);
         1: send_pixel(16'($urandom_range(0, top)), 16'($urandom_range(0, top)),
                       16'($urandom_range(0, top)), gaps);
         default: send_pixel(16'($urandom_range(0, 65535) % (top + 1)),
                             16'($urandom_range(0, 65535) % (top + 1)),
                             16'($urandom_range(0, 65535) % (top + 1)), gaps);
      endcase
   endtask

   task automatic directed_pixels();
      send_pixel(16'h0000, 16'h0000, 16'h0000, 0);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      send_pixel(16'h00FF, 16'h00FF, 16'h00FF, 0);
      send_pixel(16'h0100, 16'h0000, 16'h0000, 0);
      send_pixel(16'h007F, 16'h007F, 16'h007F, 0);
      send_pixel(16'h0080, 16'h007F, 16'h007F, 0);
      send_pixel(16'hAAAA, 16'h5555, 16'h0001, 0);
   endtask

   initial begin
      int unsigned settings[9][3];
      settings = '{'{0, 255, 255}, '{1, 255, 255}, '{1, 65535, 65535}, '{0, 65535, 1},
                   '{1, 1, 65535}, '{0, 0, 200}, '{1, 0, 0}, '{0, 1000, 0},
                   '{1, 4095, 255}};
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed_pixels();
      for (int s = 0; s < 9; s++) begin
         configure(settings[s][0][0], settings[s][1], settings[s][2]);
         directed_pixels();
         for (int n = 0; n < 150; n++) random_pixel(settings[s][1], (n % 50) < 40);
      end
      req_valid <= 0;
      stimulus_done = 1;
   end

   initial begin
      @(negedge reset);
      repeat (300) @(posedge clock);
      hold_off = 1;
      repeat (120) @(posedge clock);
      hold_off = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) pixel_board.check_result(rsp_data);
         if (hold_off) begin
            rsp_ready <= 0;
         end else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            rsp_ready <= 0;
         end else if (rsp_valid && rsp_ready) begin
            rsp_gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 11)) : 0;
            idle_cycles <= rsp_gap;
            rsp_ready <= (rsp_gap == 0);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (stimulus_done && pixel_board.pending_pixels.size() == 0) begin
            repeat (LATENCY * 2) @(posedge clock);
            if (pixel_board.error_count == 0 && !rsp_valid)
               $display("[pixel_sepia_gray_convert_top] OK");
            else
               $display("[pixel_sepia_gray_convert_top] ERROR");
            $finish;
         end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("[pixel_sepia_gray_convert_top] ERROR");
            $finish;
         end
      end
   end

endmodule
